// File: rtl/sofd_pkg.sv
// ----------------------------------------------------------------------------
// sofd_pkg
// Shared types and constants for the start/length/command/xor frame deframer.
// ----------------------------------------------------------------------------
package sofd_pkg;

    localparam logic [7:0] SOF_BYTE = 8'hFE;

    // item kind codes
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_ABANDON = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_LEN   = 3'd1,
        PH_CMDH  = 3'd2,
        PH_CMDL  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } sofd_phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } sofd_in_t;

    typedef struct packed {
        logic       is_payload;
        logic [7:0] payload_byte;
        logic [7:0] byte_position;
        logic [7:0] frame_length;
        logic [7:0] command_high;
        logic [7:0] command_low;
        logic       end_of_frame;
        logic       check_ok;
        logic [7:0] computed_check;
        logic [7:0] received_check;
    } sofd_out_t;

    // result handed from the parser to the output stage
    typedef struct packed {
        logic      valid;
        sofd_out_t item;
    } sofd_handoff_t;

endpackage

// File: rtl/sofd_parser.sv
// ----------------------------------------------------------------------------
// sofd_parser
// Frame phase machine, held header, payload count and running xor.
// ----------------------------------------------------------------------------
module sofd_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  sofd_pkg::sofd_in_t     item,
    input  logic                   out_free,
    output logic                   consume,
    output sofd_pkg::sofd_handoff_t res
);

    sofd_pkg::sofd_phase_t phase_reg, phase_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] cmd_high_reg, cmd_high_next;
    logic [7:0] cmd_low_reg, cmd_low_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] xor_reg, xor_next;

    logic       is_byte;
    logic       has_result;
    logic [7:0] b;
    logic [7:0] count_inc;
    logic [7:0] xor_data;

    assign b         = item.rx_byte;
    assign is_byte   = (item.kind == sofd_pkg::KIND_BYTE);
    assign count_inc = count_reg + 8'd1;
    assign xor_data  = xor_reg ^ b;

    assign has_result = item_valid && is_byte
                        && (phase_reg == sofd_pkg::PH_DATA || phase_reg == sofd_pkg::PH_CHECK);
    // a beat that makes a result waits for room in the output stage
    assign consume = item_valid && (!has_result || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= sofd_pkg::PH_HUNT;
            length_reg   <= 8'd0;
            cmd_high_reg <= 8'd0;
            cmd_low_reg  <= 8'd0;
            count_reg    <= 8'd0;
            xor_reg      <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            length_reg   <= length_next;
            cmd_high_reg <= cmd_high_next;
            cmd_low_reg  <= cmd_low_next;
            count_reg    <= count_next;
            xor_reg      <= xor_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        length_next   = length_reg;
        cmd_high_next = cmd_high_reg;
        cmd_low_next  = cmd_low_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;

        res.valid               = 1'b0;
        res.item.is_payload     = 1'b0;
        res.item.payload_byte   = 8'd0;
        res.item.byte_position  = 8'd0;
        res.item.frame_length   = length_reg;
        res.item.command_high   = cmd_high_reg;
        res.item.command_low    = cmd_low_reg;
        res.item.end_of_frame   = 1'b0;
        res.item.check_ok       = 1'b0;
        res.item.computed_check = xor_reg;
        res.item.received_check = 8'd0;

        if (consume)
        begin
            if (!is_byte)
            begin
                phase_next    = sofd_pkg::PH_HUNT;
                length_next   = 8'd0;
                cmd_high_next = 8'd0;
                cmd_low_next  = 8'd0;
                count_next    = 8'd0;
                xor_next      = 8'd0;
            end
            else
            begin
                case (phase_reg)
                    sofd_pkg::PH_HUNT:
                    begin
                        if (b == sofd_pkg::SOF_BYTE)
                        begin
                            phase_next    = sofd_pkg::PH_LEN;
                            length_next   = 8'd0;
                            cmd_high_next = 8'd0;
                            cmd_low_next  = 8'd0;
                            count_next    = 8'd0;
                            xor_next      = 8'd0;
                        end
                    end
                    sofd_pkg::PH_LEN:
                    begin
                        length_next = b;
                        xor_next    = b;
                        phase_next  = sofd_pkg::PH_CMDH;
                    end
                    sofd_pkg::PH_CMDH:
                    begin
                        cmd_high_next = b;
                        xor_next      = xor_data;
                        phase_next    = sofd_pkg::PH_CMDL;
                    end
                    sofd_pkg::PH_CMDL:
                    begin
                        cmd_low_next = b;
                        xor_next     = xor_data;
                        count_next   = 8'd0;
                        phase_next   = (length_reg == 8'd0) ? sofd_pkg::PH_CHECK
                                                            : sofd_pkg::PH_DATA;
                    end
                    sofd_pkg::PH_DATA:
                    begin
                        xor_next                = xor_data;
                        count_next              = count_inc;
                        res.valid               = 1'b1;
                        res.item.is_payload     = 1'b1;
                        res.item.payload_byte   = b;
                        res.item.byte_position  = count_reg;
                        res.item.computed_check = xor_data;
                        if (count_inc == length_reg)
                        begin
                            phase_next = sofd_pkg::PH_CHECK;
                        end
                    end
                    sofd_pkg::PH_CHECK:
                    begin
                        res.valid               = 1'b1;
                        res.item.end_of_frame   = 1'b1;
                        res.item.check_ok       = (xor_reg == b);
                        res.item.received_check = b;
                        phase_next    = sofd_pkg::PH_HUNT;
                        length_next   = 8'd0;
                        cmd_high_next = 8'd0;
                        cmd_low_next  = 8'd0;
                        count_next    = 8'd0;
                        xor_next      = 8'd0;
                    end
                    default:
                    begin
                        phase_next    = sofd_pkg::PH_HUNT;
                        length_next   = 8'd0;
                        cmd_high_next = 8'd0;
                        cmd_low_next  = 8'd0;
                        count_next    = 8'd0;
                        xor_next      = 8'd0;
                    end
                endcase
            end
        end
    end

    // a result is only produced by a beat that is taken
    a_res_needs_consume: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> consume && out_free)
        else $error("result produced without room in output stage");

    // last payload beat moves on to the check byte
    a_last_payload_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && is_byte && phase_reg == sofd_pkg::PH_DATA && count_inc == length_reg)
        |=> phase_reg == sofd_pkg::PH_CHECK)
        else $error("last payload byte did not lead to check phase");

    // frame end leaves a clean frame context
    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.item.end_of_frame)
        |=> phase_reg == sofd_pkg::PH_HUNT && xor_reg == 8'd0 && count_reg == 8'd0)
        else $error("frame end did not clear frame context");

    // hunting always runs with a cleared context
    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sofd_pkg::PH_HUNT
        |-> xor_reg == 8'd0 && count_reg == 8'd0 && length_reg == 8'd0)
        else $error("stale frame context while hunting");

endmodule

// File: rtl/sofd_out_stage.sv
// ----------------------------------------------------------------------------
// sofd_out_stage
// Result register that holds a beat until the receiver takes it.
// ----------------------------------------------------------------------------
module sofd_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sofd_pkg::sofd_handoff_t res,
    output logic                    free,
    output logic                    result_valid,
    input  logic                    result_stall,
    output sofd_pkg::sofd_out_t     result_item
);

    logic                valid_reg, valid_next;
    sofd_pkg::sofd_out_t item_reg, item_next;

    // room when empty or the held beat leaves this edge
    assign free = !valid_reg || !result_stall;

    always_comb
    begin
        item_next = item_reg;
        if (res.valid)
        begin
            valid_next = 1'b1;
            item_next  = res.item;
        end
        else
        begin
            valid_next = valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

endmodule

// File: rtl/sof_length_xor_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// sof_length_xor_frame_deframer_unit
// Byte stream deframer: start byte, length, two command bytes, payload, xor.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel (byte_valid / byte_stall / byte_item) takes one received
//   byte or an abandon beat per cycle while byte_stall is low. result channel (result_valid /
//   result_stall / result_item) gives one beat per payload byte and one
//   frame end beat per check byte, with computed and received xor and ok.
//   Header and hunting bytes give no result beat.
//   A byte accepted on the byte channel passes through the input register,
//   then the phase/xor logic into the result register.
//   Throughput: one byte per cycle while result_stall holds no result beat,
//   set by the single phase step and xor between the input and result registers.
//   Stall: while result_stall holds a result beat, a byte that would make
//   a new result waits in the input register and byte_stall rises; bytes
//   that make no result still pass through.
//   Reset (rst_n low, asynchronous) empties both registers and returns to
//   hunting for the start byte with a cleared header, count and xor.
// ----------------------------------------------------------------------------
module sof_length_xor_frame_deframer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  sofd_pkg::sofd_in_t  byte_item,
    output logic                result_valid,
    input  logic                result_stall,
    output sofd_pkg::sofd_out_t result_item
);

    logic                    in_valid_reg, in_valid_next;
    sofd_pkg::sofd_in_t      in_item_reg, in_item_next;
    logic                    consume;
    logic                    out_free;
    logic                    accept;
    sofd_pkg::sofd_handoff_t res;

    assign byte_stall = in_valid_reg && !consume;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg && !consume;
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_item_next  = byte_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    sofd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .out_free   (out_free),
        .consume    (consume),
        .res        (res)
    );

    sofd_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule
